// ===== design/assert_macros.svh =====
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ptq_pkg.sv =====
// Shared request codes, status codes and controller-datapath types of the task queue.
package ptq_pkg;

   // request codes
   localparam logic [2:0] REQ_INS_HEAD  = 3'd0;
   localparam logic [2:0] REQ_INS_TAIL  = 3'd1;
   localparam logic [2:0] REQ_INS_SORT  = 3'd2;
   localparam logic [2:0] REQ_REM_FRONT = 3'd3;
   localparam logic [2:0] REQ_REM_REAR  = 3'd4;
   localparam logic [2:0] REQ_REM_NAMED = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // which cells raise their position flag when an item is captured
   localparam logic [2:0] SEL_ALL   = 3'd0;  // every cell: head insert
   localparam logic [2:0] SEL_TAIL  = 3'd1;  // first free cell
   localparam logic [2:0] SEL_LAST  = 3'd2;  // last occupied cell
   localparam logic [2:0] SEL_FIRST = 3'd3;  // cell zero
   localparam logic [2:0] SEL_PRIO  = 3'd4;  // first lower priority, else first free
   localparam logic [2:0] SEL_ID    = 3'd5;  // occupied cells holding the named id

   // shift operation applied in the execute cycle
   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic       capture;   // latch request fields and cell flags
      logic [2:0] flag_sel;
      logic       exec;      // apply shift and load result registers
      logic [1:0] op;
      logic [1:0] status;    // status decided by the controller
   } ptq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ptq_stat_type;

endpackage

// ===== design/ptq_ctrl.sv =====
// Controller state machine of the task queue: accept, decide, execute.
module ptq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_type,
   input  ptq_pkg::ptq_stat_type stat,
   output logic                 busy,
   output logic                 rsp_valid,
   output ptq_pkg::ptq_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic       state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [1:0] st_ff, st_in;
   logic       strobe_ff;
   logic       accept;
   logic [2:0] sel;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff == S_EXEC);

   always_comb begin
      op_in = ptq_pkg::OP_NONE;
      st_in = ptq_pkg::ST_OK;
      sel   = ptq_pkg::SEL_ALL;
      unique case (req_type)
         ptq_pkg::REQ_INS_HEAD, ptq_pkg::REQ_INS_TAIL, ptq_pkg::REQ_INS_SORT: begin
            if (stat.full) begin
               st_in = ptq_pkg::ST_FULL;
            end else begin
               op_in = ptq_pkg::OP_INSERT;
            end
            if (req_type == ptq_pkg::REQ_INS_TAIL) begin
               sel = ptq_pkg::SEL_TAIL;
            end else if (req_type == ptq_pkg::REQ_INS_SORT) begin
               sel = ptq_pkg::SEL_PRIO;
            end
         end
         ptq_pkg::REQ_REM_FRONT, ptq_pkg::REQ_REM_REAR, ptq_pkg::REQ_REM_NAMED: begin
            if (stat.empty) begin
               st_in = ptq_pkg::ST_EMPTY;
            end else begin
               op_in = ptq_pkg::OP_REMOVE;
            end
            if (req_type == ptq_pkg::REQ_REM_FRONT) begin
               sel = ptq_pkg::SEL_FIRST;
            end else if (req_type == ptq_pkg::REQ_REM_REAR) begin
               sel = ptq_pkg::SEL_LAST;
            end else begin
               sel = ptq_pkg::SEL_ID;
            end
         end
         default: begin
            // unused codes: no change, status ok
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_EXEC;
         S_EXEC: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         op_ff     <= ptq_pkg::OP_NONE;
         st_ff     <= ptq_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == S_EXEC);
         if (accept) begin
            op_ff <= op_in;
            st_ff <= st_in;
         end
      end
   end

   assign rsp_valid    = strobe_ff;
   assign cmd.capture  = accept;
   assign cmd.flag_sel = sel;
   assign cmd.exec     = (state_ff == S_EXEC);
   assign cmd.op       = op_ff;
   assign cmd.status   = st_ff;

endmodule

// ===== design/ptq_datapath.sv =====
// Shift-cell array, position flags, entry count and result registers of the task queue.
module ptq_datapath #(
   parameter int MAX_TASKS     = 32,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptq_pkg::ptq_cmd_type  cmd,
   input  logic [4:0]            req_task_id,
   input  logic [7:0]            req_task_priority,
   output ptq_pkg::ptq_stat_type stat,
   output logic [4:0]            rsp_removed_id,
   output logic [1:0]            rsp_status,
   output logic [5:0]            rsp_count_after
);

   localparam int CW   = $clog2(MAX_TASKS + 1);
   localparam int PW   = PRIORITY_BITS;
   localparam int PEXT = (PW > 8) ? PW : 8;
   localparam int CEXT = (CW > 6) ? CW : 6;

   logic [4:0]    task_ff [MAX_TASKS];
   logic [PW-1:0] prio_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] flag_ff, flag_in;
   logic [CW-1:0] count_ff, count_in;
   logic [4:0]    id_ff;
   logic [PW-1:0] newp_ff, newp_in;
   logic [MAX_TASKS-1:0] mark, first;
   logic [4:0]    pick [MAX_TASKS];
   logic          found;
   logic [4:0]    removed_in;
   logic [1:0]    status_in;
   logic [CEXT-1:0] count_ext;
   logic [4:0]    res_id_ff;
   logic [1:0]    res_st_ff;
   logic [5:0]    res_cnt_ff;

   logic [PEXT-1:0] prio_ext;
   assign prio_ext = PEXT'(req_task_priority);
   assign newp_in  = prio_ext[PW-1:0];

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(MAX_TASKS));

   // position flags, evaluated against the queue as it stands at capture
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_flag
      logic occupied;
      assign occupied = (CW'(i) < count_ff);
      always_comb begin
         unique case (cmd.flag_sel)
            ptq_pkg::SEL_ALL:   flag_in[i] = 1'b1;
            ptq_pkg::SEL_TAIL:  flag_in[i] = (count_ff == CW'(i));
            ptq_pkg::SEL_LAST:  flag_in[i] = (count_ff == CW'(i + 1));
            ptq_pkg::SEL_FIRST: flag_in[i] = (i == 0);
            ptq_pkg::SEL_PRIO:  flag_in[i] = (occupied && (prio_ff[i] < newp_in))
                                             || (count_ff == CW'(i));
            ptq_pkg::SEL_ID:    flag_in[i] = occupied && (task_ff[i] == req_task_id);
            default:            flag_in[i] = 1'b0;
         endcase
      end
   end

   // mark: cell at or beyond the chosen position; first: the position itself
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_mark
      if (i == 0) begin : g_head
         assign mark[i]  = flag_ff[i];
         assign first[i] = flag_ff[i];
         assign pick[i]  = first[i] ? task_ff[i] : 5'd0;
      end else begin : g_body
         assign mark[i]  = mark[i-1] | flag_ff[i];
         assign first[i] = flag_ff[i] & ~mark[i-1];
         assign pick[i]  = pick[i-1] | (first[i] ? task_ff[i] : 5'd0);
      end
   end
   assign found = mark[MAX_TASKS-1];

   // shift cells: open a gap on insert, close it on remove
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      always_ff @(posedge clock) begin
         if (cmd.exec && (cmd.op == ptq_pkg::OP_INSERT)) begin
            if (first[i]) begin
               task_ff[i] <= id_ff;
               prio_ff[i] <= newp_ff;
            end else if (i > 0 && mark[(i > 0) ? i - 1 : 0]) begin
               task_ff[i] <= task_ff[(i > 0) ? i - 1 : 0];
               prio_ff[i] <= prio_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.exec && (cmd.op == ptq_pkg::OP_REMOVE) && found) begin
            if (i < MAX_TASKS - 1 && mark[i]) begin
               task_ff[i] <= task_ff[(i < MAX_TASKS - 1) ? i + 1 : i];
               prio_ff[i] <= prio_ff[(i < MAX_TASKS - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      removed_in = 5'd0;
      status_in  = cmd.status;
      unique case (cmd.op)
         ptq_pkg::OP_INSERT: count_in = count_ff + CW'(1);
         ptq_pkg::OP_REMOVE: begin
            if (found) begin
               count_in   = count_ff - CW'(1);
               removed_in = pick[MAX_TASKS-1];
            end else begin
               status_in = ptq_pkg::ST_NOTFOUND;
            end
         end
         default: begin
         end
      endcase
   end

   assign count_ext = CEXT'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         flag_ff <= flag_in;
         id_ff   <= req_task_id;
         newp_ff <= newp_in;
      end
      if (cmd.exec) begin
         res_id_ff  <= removed_in;
         res_st_ff  <= status_in;
         res_cnt_ff <= count_ext[5:0];
      end
   end

   assign rsp_removed_id  = res_id_ff;
   assign rsp_status      = res_st_ff;
   assign rsp_count_after = res_cnt_ff;

endmodule

// ===== design/priority_task_queue.sv =====
// Top level of the priority task queue: controller plus shift-cell datapath.
//
//   channel   ports                                      handshake
//   request   req_type, req_task_id, req_task_priority   start high while busy low
//   result    rsp_removed_id, rsp_status, rsp_count_after rsp_valid, one cycle
//
// For each item the accept edge latches the request and a position flag per cell,
// and the execute cycle shifts the cells and loads the result.
// busy is high during the execute cycle only, so a new item can be accepted in
// the cycle the result strobe is shown, once the flag-then-shift step of the
// cell array is through with the previous item.
// Synchronous reset empties the queue; cell contents are left as they are.
// The receiver cannot stall: rsp_valid lasts exactly one cycle per item.
`include "assert_macros.svh"

module priority_task_queue #(
   parameter int MAX_TASKS     = 32,
   parameter int PRIORITY_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_type,
   input  logic [4:0] req_task_id,
   input  logic [7:0] req_task_priority,
   output logic       rsp_valid,
   output logic [4:0] rsp_removed_id,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_count_after
);

   ptq_pkg::ptq_cmd_type  cmd;
   ptq_pkg::ptq_stat_type stat;

   // sequence each item: decide op and status from the code and the fill level
   ptq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // hold the entries, locate the position, shift, and register the result
   ptq_datapath #(
      .MAX_TASKS     (MAX_TASKS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .stat              (stat),
      .rsp_removed_id    (rsp_removed_id),
      .rsp_status        (rsp_status),
      .rsp_count_after   (rsp_count_after)
   );

   // an accepted item always enters the execute cycle
   `ASSERT_CLKD(a_accept_exec, clock, reset, (start && !busy) |=> busy, "accept without execute")
   // the result strobe follows the execute cycle
   `ASSERT_CLKD(a_exec_strobe, clock, reset, busy |=> rsp_valid, "execute without result")
   // the strobe never overlaps an item in flight
   `ASSERT_CLKD(a_strobe_idle, clock, reset, rsp_valid |-> !busy, "result during execute")
   // a refused or failed request removes nothing
   `ASSERT_CLKD(a_fail_no_id, clock, reset,
      (rsp_valid && (rsp_status != ptq_pkg::ST_OK)) |-> (rsp_removed_id == 5'd0),
      "removed id on failed request")

endmodule

// ===== test/tb_priority_task_queue.sv =====
// Self-checking testbench for the priority task queue: directed corner cases, then random traffic.
module tb_priority_task_queue;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_TASKS     = 32;
   localparam int PRIORITY_BITS = 8;
   localparam int ITEMS         = 650;   // random items that reach the queue logic
   localparam int IDLE_LIMIT    = 1000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES  = 4;     // cycles watched for stray results after the last owed one

   // request codes that the block ignores
   localparam logic [2:0] REQ_SPARE_LO = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;

   // traffic shapes for the random part
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIX   = 2;

   typedef struct {
      logic [4:0] id;
      logic [7:0] prio;
   } slot_type;

   typedef struct {
      logic [4:0] removed_id;
      logic [1:0] status;
      logic [5:0] count_after;
   } outcome_type;

   // Mirror of the queue contents plus the outcomes still owed by the block.
   class ready_queue_board_type;
      slot_type    slots[$];
      outcome_type owed[$];
      int       errors;
      int       checked;
      int       full_refusals;
      int       empty_removes;
      int       named_misses;
      int       peak_depth;

      function new();
         errors = 0;
         checked = 0;
         full_refusals = 0;
         empty_removes = 0;
         named_misses = 0;
         peak_depth = 0;
      endfunction

      function int depth();
         return slots.size();
      endfunction

      function int outstanding();
         return owed.size();
      endfunction

      // id of some queued task, for named removals that hit
      function logic [4:0] queued_id();
         return slots[$urandom_range(0, slots.size() - 1)].id;
      endfunction

      // apply one accepted request to the mirror and queue its outcome
      function void record_request(logic [2:0] kind, logic [4:0] id, logic [7:0] prio);
         outcome_type want;
         slot_type    fresh;
         int       pos;
         want.removed_id = '0;
         want.status     = ptq_pkg::ST_OK;
         fresh.id        = id;
         fresh.prio      = prio;
         pos             = 0;
         case (kind)
            ptq_pkg::REQ_INS_HEAD, ptq_pkg::REQ_INS_TAIL, ptq_pkg::REQ_INS_SORT: begin
               if (slots.size() >= MAX_TASKS) begin
                  want.status = ptq_pkg::ST_FULL;
                  full_refusals++;
               end else begin
                  if (kind == ptq_pkg::REQ_INS_TAIL) begin
                     pos = slots.size();
                  end else if (kind == ptq_pkg::REQ_INS_SORT) begin
                     // equal priorities stay ahead of the newcomer
                     while (pos < slots.size() && slots[pos].prio >= prio) pos++;
                  end
                  if (pos == slots.size()) slots.push_back(fresh);
                  else slots.insert(pos, fresh);
               end
            end
            ptq_pkg::REQ_REM_FRONT, ptq_pkg::REQ_REM_REAR, ptq_pkg::REQ_REM_NAMED: begin
               if (slots.size() == 0) begin
                  want.status = ptq_pkg::ST_EMPTY;
                  empty_removes++;
               end else begin
                  if (kind == ptq_pkg::REQ_REM_REAR) begin
                     pos = slots.size() - 1;
                  end else if (kind == ptq_pkg::REQ_REM_NAMED) begin
                     while (pos < slots.size() && slots[pos].id != id) pos++;
                  end
                  if (pos == slots.size()) begin
                     want.status = ptq_pkg::ST_NOTFOUND;
                     named_misses++;
                  end else begin
                     want.removed_id = slots[pos].id;
                     slots.delete(pos);
                  end
               end
            end
            default: ;
         endcase
         want.count_after = 6'(slots.size());
         if (slots.size() > peak_depth) peak_depth = slots.size();
         owed.push_back(want);
      endfunction

      // compare one strobed result with the oldest owed outcome
      function void compare_result(logic [4:0] removed_id, logic [1:0] status,
                                   logic [5:0] count_after);
         outcome_type want;
         if (owed.size() == 0) begin
            $error("unexpected result: removed_id %0d status %0d count_after %0d",
                   removed_id, status, count_after);
            errors++;
            return;
         end
         want = owed.pop_front();
         checked++;
         if (removed_id !== want.removed_id) begin
            $error("rsp_removed_id: expected %0d, actual %0d", want.removed_id, removed_id);
            errors++;
         end
         if (status !== want.status) begin
            $error("rsp_status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (count_after !== want.count_after) begin
            $error("rsp_count_after: expected %0d, actual %0d", want.count_after, count_after);
            errors++;
         end
      endfunction
   endclass

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       start             = 1'b0;
   logic [2:0] req_type          = '0;
   logic [4:0] req_task_id       = '0;
   logic [7:0] req_task_priority = '0;
   logic       busy;
   logic       rsp_valid;
   logic [4:0] rsp_removed_id;
   logic [1:0] rsp_status;
   logic [5:0] rsp_count_after;

   ready_queue_board_type board = new();
   int items_done = 0;   // random items counted toward ITEMS
   int burst_left = 0;   // items left in the current sender burst
   int idle_cycles = 0;  // cycles since the last handshake on either side

   priority_task_queue #(
      .MAX_TASKS        (MAX_TASKS),
      .PRIORITY_BITS    (PRIORITY_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_task_id      (req_task_id),
      .req_task_priority(req_task_priority),
      .rsp_valid        (rsp_valid),
      .rsp_removed_id   (rsp_removed_id),
      .rsp_status       (rsp_status),
      .rsp_count_after  (rsp_count_after)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Sample results and handshakes at the edge; values read here are the ones
   // held in the cycle that the edge closes.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) board.compare_result(rsp_removed_id, rsp_status, rsp_count_after);
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one item and hold it until the block takes it; return on the
   // accepting edge with start still high.
   task automatic send_item(input logic [2:0] kind, input logic [4:0] id,
                            input logic [7:0] prio);
      start             <= 1'b1;
      req_type          <= kind;
      req_task_id       <= id;
      req_task_priority <= prio;
      do @(posedge clock); while (busy);
      board.record_request(kind, id, prio);
      if (kind <= ptq_pkg::REQ_REM_NAMED) items_done++;
   endtask

   // Sender pacing: bursts of random length, each followed by a short gap.
   // Long bursts give stretches with no idling at all.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Draw one random item shaped by the traffic mode.
   task automatic make_item(input int mode, output logic [2:0] kind,
                            output logic [4:0] id, output logic [7:0] prio);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  kind = (roll < 90)
               ? 3'($urandom_range(ptq_pkg::REQ_INS_HEAD, ptq_pkg::REQ_INS_SORT))
               : 3'($urandom_range(ptq_pkg::REQ_REM_FRONT, ptq_pkg::REQ_REM_NAMED));
         MODE_DRAIN: kind = (roll < 90)
               ? 3'($urandom_range(ptq_pkg::REQ_REM_FRONT, ptq_pkg::REQ_REM_NAMED))
               : 3'($urandom_range(ptq_pkg::REQ_INS_HEAD, ptq_pkg::REQ_INS_SORT));
         default:    kind = (roll < 4)
               ? 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI))
               : 3'($urandom_range(ptq_pkg::REQ_INS_HEAD, ptq_pkg::REQ_REM_NAMED));
      endcase
      // named removals mostly target a queued task; a small id pool breeds duplicates
      if (kind == ptq_pkg::REQ_REM_NAMED && board.depth() > 0 && $urandom_range(0, 9) < 7)
         id = board.queued_id();
      else if ($urandom_range(0, 2) == 0)
         id = 5'($urandom_range(0, 3));
      else
         id = 5'($urandom_range(0, 31));
      // favor the extremes and a few shared values so ties are common
      case ($urandom_range(0, 4))
         0:       prio = 8'd0;
         1:       prio = 8'd255;
         2:       prio = 8'($urandom_range(0, 3) * 85);
         default: prio = 8'($urandom_range(0, 255));
      endcase
   endtask

   // Fill runs until the queue is full and a few inserts are refused; drain
   // runs until it is empty and a few removes bounce; mix runs a random span.
   task automatic run_episode(input int mode);
      logic [2:0] kind;
      logic [4:0] id;
      logic [7:0] prio;
      int         extra;
      int         span;
      int         steps;
      extra = $urandom_range(1, 4);
      span  = $urandom_range(10, 40);
      steps = 0;
      while (items_done < ITEMS && steps < 80) begin
         make_item(mode, kind, id, prio);
         send_item(kind, id, prio);
         pace();
         steps++;
         if (mode == MODE_FILL && board.depth() == MAX_TASKS) extra--;
         if (mode == MODE_DRAIN && board.depth() == 0) extra--;
         if (extra == 0 || (mode == MODE_MIX && steps >= span)) break;
      end
   endtask

   // Give up if the block stops taking items or producing results.
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every kind of removal on an empty queue, then an unused code
      send_item(ptq_pkg::REQ_REM_FRONT, 5'd0, 8'd0);
      send_item(ptq_pkg::REQ_REM_REAR, 5'd31, 8'd255);
      send_item(ptq_pkg::REQ_REM_NAMED, 5'd5, 8'd0);
      send_item(REQ_SPARE_LO, 5'd31, 8'd255);
      // field extremes at both ends
      send_item(ptq_pkg::REQ_INS_HEAD, 5'd31, 8'd255);
      send_item(ptq_pkg::REQ_INS_TAIL, 5'd0, 8'd0);
      // sorted inserts: middle, tie behind an equal, tie at the head, tie at the tail
      send_item(ptq_pkg::REQ_INS_SORT, 5'd7, 8'd128);
      send_item(ptq_pkg::REQ_INS_SORT, 5'd8, 8'd128);
      send_item(ptq_pkg::REQ_INS_SORT, 5'd9, 8'd255);
      send_item(ptq_pkg::REQ_INS_SORT, 5'd10, 8'd0);
      // sorted insert above the head's priority lands at the head
      send_item(ptq_pkg::REQ_INS_HEAD, 5'd12, 8'd100);
      send_item(ptq_pkg::REQ_INS_SORT, 5'd13, 8'd200);
      // duplicate id: named removal takes the copy nearest the head
      send_item(ptq_pkg::REQ_INS_HEAD, 5'd7, 8'd1);
      send_item(ptq_pkg::REQ_REM_NAMED, 5'd7, 8'd0);
      // named miss, then an unused code
      send_item(ptq_pkg::REQ_REM_NAMED, 5'd20, 8'd0);
      send_item(REQ_SPARE_HI, 5'd21, 8'd170);
      // named removal of the tail, then plain rear and front
      send_item(ptq_pkg::REQ_REM_NAMED, 5'd10, 8'd0);
      send_item(ptq_pkg::REQ_REM_REAR, 5'd0, 8'd0);
      send_item(ptq_pkg::REQ_REM_FRONT, 5'd0, 8'd0);
      send_item(ptq_pkg::REQ_REM_NAMED, 5'd8, 8'd0);
      items_done = 0;

      // open with a fill so the full queue is reached early, then mix it up
      burst_left = $urandom_range(1, 8);
      run_episode(MODE_FILL);
      while (items_done < ITEMS) run_episode($urandom_range(MODE_FILL, MODE_MIX));
      start <= 1'b0;

      // hold until every owed result has arrived, then watch for strays
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d random items and %0d checked results, peak depth %0d of %0d.",
               items_done, board.checked, board.peak_depth, MAX_TASKS);
      $display("Refused inserts on full %0d, removes on empty %0d, named misses %0d.",
               board.full_refusals, board.empty_removes, board.named_misses);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/ptq_pkg.sv
design/ptq_ctrl.sv
design/ptq_datapath.sv
design/priority_task_queue.sv
test/tb_priority_task_queue.sv
